// ===== rtl/gpta_pkg.sv =====
// Shared types and constants for the GF(2^m) power-table arithmetic block.
package gpta_pkg;

    localparam int MAX_DEGREE_DEF = 8;
    localparam int OPCODE_W       = 2;
    localparam int EXP_W          = 8;
    localparam int VALUE_W        = 8;
    localparam int STATUS_W       = 2;
    localparam int DEGREE_W       = 4;
    localparam int MASK_W         = 8;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 8;

    localparam logic [DEGREE_W-1:0] DEGREE_RESET = 4'd8;
    localparam logic [MASK_W-1:0]   MASK_RESET   = 8'd29;

    localparam logic [CFG_INDEX_W-1:0] REG_FIELD_DEGREE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REDUCTION_MASK = 2'd1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_BUILD = 2'd0,
        OP_MUL   = 2'd1,
        OP_ADD   = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_RANGE     = 2'd1,
        STAT_NOT_BUILT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_BUILD  = 2'd1,
        S_LOOKUP = 2'd2,
        S_RESULT = 2'd3
    } state_t;

endpackage

// ===== rtl/gpta_table_mem.sv =====
// Power table memory: one write port and two registered read ports.
module gpta_table_mem #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8,
    parameter int DEPTH  = 255
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr0,
    input  logic [ADDR_W-1:0] raddr1,
    output logic [DATA_W-1:0] rdata0,
    output logic [DATA_W-1:0] rdata1
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// ===== rtl/gpta_ctrl.sv =====
// Sequencer: configuration registers, table build, lookups and the result register.
module gpta_ctrl #(
    parameter int MAX_DEGREE = gpta_pkg::MAX_DEGREE_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [2*gpta_pkg::EXP_W-1:0]       s_tdata,
    input  logic [gpta_pkg::OPCODE_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gpta_pkg::VALUE_W-1:0]       m_tdata,
    output logic [gpta_pkg::STATUS_W-1:0]      m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gpta_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gpta_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               mem_we,
    output logic [MAX_DEGREE-1:0]              mem_waddr,
    output logic [MAX_DEGREE-1:0]              mem_wdata,
    output logic [MAX_DEGREE-1:0]              mem_raddr0,
    output logic [MAX_DEGREE-1:0]              mem_raddr1,
    input  logic [MAX_DEGREE-1:0]              mem_rdata0,
    input  logic [MAX_DEGREE-1:0]              mem_rdata1
);

    localparam int M  = MAX_DEGREE;
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int CW = (DW > gpta_pkg::DEGREE_W) ? DW : gpta_pkg::DEGREE_W;
    localparam int OW = (M > gpta_pkg::EXP_W) ? M : gpta_pkg::EXP_W;

    gpta_pkg::state_t state_reg, state_next;

    logic [gpta_pkg::DEGREE_W-1:0] degree_reg;
    logic [gpta_pkg::MASK_W-1:0]   mask_reg;
    logic                          built_reg;

    logic [M-1:0] order_reg;
    logic [M-1:0] low_reg;
    logic [M-1:0] k_reg;
    logic [M-1:0] x_reg;
    logic [M-1:0] x_next;
    gpta_pkg::opcode_t op_reg;

    logic [M-1:0]         pend_value_reg;
    gpta_pkg::status_t    pend_status_reg;

    logic                      out_valid_reg;
    logic [gpta_pkg::VALUE_W-1:0] out_value_reg;
    gpta_pkg::status_t         out_status_reg;

    logic              accept;
    logic              out_load;
    logic              build_last;
    gpta_pkg::opcode_t in_op;
    logic [CW-1:0]     fd_ext;
    logic [CW-1:0]     d_eff;
    logic [M-1:0]      order_cur;
    logic [M-1:0]      low_cur;
    logic [OW:0]       a_ext;
    logic [OW:0]       b_ext;
    logic [OW:0]       ord_ext;
    logic [OW:0]       sum;
    logic [OW:0]       e_idx;
    logic              in_range;
    logic              is_query;
    logic [M:0]        x_shift;
    logic              x_over;
    gpta_pkg::status_t in_status;

    always_comb begin
        in_op    = gpta_pkg::opcode_t'(s_tuser);
        accept   = s_tvalid && s_tready;
        is_query = (in_op == gpta_pkg::OP_MUL) || (in_op == gpta_pkg::OP_ADD);

        fd_ext = CW'(degree_reg);
        if (fd_ext < CW'(2)) begin
            d_eff = CW'(2);
        end else if (fd_ext > CW'(MAX_DEGREE)) begin
            d_eff = CW'(MAX_DEGREE);
        end else begin
            d_eff = fd_ext;
        end
        order_cur = {M{1'b1}} >> (CW'(M) - d_eff);
        low_cur   = M'(mask_reg) & order_cur;

        a_ext    = (OW + 1)'(s_tdata[gpta_pkg::EXP_W-1:0]);
        b_ext    = (OW + 1)'(s_tdata[2*gpta_pkg::EXP_W-1:gpta_pkg::EXP_W]);
        ord_ext  = (OW + 1)'(order_cur);
        in_range = (a_ext < ord_ext) && (b_ext < ord_ext);
        sum      = a_ext + b_ext;
        e_idx    = (sum >= ord_ext) ? (sum - ord_ext) : sum;

        if (is_query && !built_reg) begin
            in_status = gpta_pkg::STAT_NOT_BUILT;
        end else if (is_query && !in_range) begin
            in_status = gpta_pkg::STAT_RANGE;
        end else begin
            in_status = gpta_pkg::STAT_OK;
        end

        x_shift    = {x_reg, 1'b0};
        x_over     = |(x_shift & ~{1'b0, order_reg});
        x_next     = x_over ? ((x_shift[M-1:0] & order_reg) ^ low_reg) : x_shift[M-1:0];
        build_last = (k_reg == (order_reg - M'(1)));

        out_load = (state_reg == gpta_pkg::S_RESULT) && (!out_valid_reg || m_tready);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gpta_pkg::S_IDLE: begin
                if (accept) begin
                    if (in_op == gpta_pkg::OP_BUILD) begin
                        state_next = gpta_pkg::S_BUILD;
                    end else if (is_query && built_reg && in_range) begin
                        state_next = gpta_pkg::S_LOOKUP;
                    end else begin
                        state_next = gpta_pkg::S_RESULT;
                    end
                end
            end
            gpta_pkg::S_BUILD: begin
                if (build_last) begin
                    state_next = gpta_pkg::S_RESULT;
                end
            end
            gpta_pkg::S_LOOKUP: begin
                state_next = gpta_pkg::S_RESULT;
            end
            gpta_pkg::S_RESULT: begin
                if (out_load) begin
                    state_next = gpta_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = gpta_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == gpta_pkg::S_IDLE);
        cfg_ready  = 1'b1;
        mem_we     = (state_reg == gpta_pkg::S_BUILD);
        mem_waddr  = k_reg;
        mem_wdata  = x_reg;
        mem_raddr0 = (in_op == gpta_pkg::OP_MUL) ? e_idx[M-1:0] : a_ext[M-1:0];
        mem_raddr1 = b_ext[M-1:0];
        m_tvalid   = out_valid_reg;
        m_tdata    = out_value_reg;
        m_tuser    = out_status_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gpta_pkg::S_IDLE;
            degree_reg    <= gpta_pkg::DEGREE_RESET;
            mask_reg      <= gpta_pkg::MASK_RESET;
            built_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == gpta_pkg::REG_FIELD_DEGREE) begin
                    degree_reg <= cfg_data[gpta_pkg::DEGREE_W-1:0];
                    built_reg  <= 1'b0;
                end else if (cfg_index == gpta_pkg::REG_REDUCTION_MASK) begin
                    mask_reg  <= cfg_data[gpta_pkg::MASK_W-1:0];
                    built_reg <= 1'b0;
                end
            end else if ((state_reg == gpta_pkg::S_BUILD) && build_last) begin
                built_reg <= 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg          <= in_op;
            order_reg       <= order_cur;
            low_reg         <= low_cur;
            k_reg           <= '0;
            x_reg           <= M'(1);
            pend_value_reg  <= '0;
            pend_status_reg <= in_status;
        end else if (state_reg == gpta_pkg::S_BUILD) begin
            k_reg <= k_reg + M'(1);
            x_reg <= x_next;
        end else if (state_reg == gpta_pkg::S_LOOKUP) begin
            pend_value_reg  <= (op_reg == gpta_pkg::OP_MUL) ? mem_rdata0
                                                            : (mem_rdata0 ^ mem_rdata1);
            pend_status_reg <= gpta_pkg::STAT_OK;
        end
        if (out_load) begin
            out_value_reg  <= gpta_pkg::VALUE_W'(pend_value_reg);
            out_status_reg <= pend_status_reg;
        end
    end

endmodule

// ===== rtl/gf2m_power_table_arithmetic.sv =====
// Top level of the GF(2^m) power-table arithmetic block.
// A build item fills the power table one entry per cycle on the single write port of the
// table memory; once the last entry is written, its result moves to the output register.
// An add item reads both table entries together on the two read ports, while a multiply
// item reads only the entry at the summed exponent; the result passes through the table
// read and the pending result register before it enters the output register. An item that
// fails its checks, or carries no operation, skips the table read. One item is worked on
// at a time, and the next is accepted in the cycle after the previous result has moved
// into the output register; a result waits as long as the output register stays full.
// Configuration writes are taken in any cycle, those to the degree or mask register clear the
// built flag, and configuration writes must only be issued while the block is idle.
module gf2m_power_table_arithmetic #(
    parameter int MAX_DEGREE = gpta_pkg::MAX_DEGREE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [2*gpta_pkg::EXP_W-1:0]     s_tdata,   // exp_a, exp_b
    input  logic [gpta_pkg::OPCODE_W-1:0]    s_tuser,   // opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gpta_pkg::VALUE_W-1:0]     m_tdata,   // value
    output logic [gpta_pkg::STATUS_W-1:0]    m_tuser,   // status
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gpta_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gpta_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH = (1 << MAX_DEGREE) - 1;

    logic                  mem_we;
    logic [MAX_DEGREE-1:0] mem_waddr;
    logic [MAX_DEGREE-1:0] mem_wdata;
    logic [MAX_DEGREE-1:0] mem_raddr0;
    logic [MAX_DEGREE-1:0] mem_raddr1;
    logic [MAX_DEGREE-1:0] mem_rdata0;
    logic [MAX_DEGREE-1:0] mem_rdata1;

    gpta_ctrl #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr0 (mem_raddr0),
        .mem_raddr1 (mem_raddr1),
        .mem_rdata0 (mem_rdata0),
        .mem_rdata1 (mem_rdata1)
    );

    gpta_table_mem #(
        .ADDR_W(MAX_DEGREE),
        .DATA_W(MAX_DEGREE),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk   (aclk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr0 (mem_raddr0),
        .raddr1 (mem_raddr1),
        .rdata0 (mem_rdata0),
        .rdata1 (mem_rdata1)
    );

endmodule
